// ===== rtl/core/sha_pkg.sv =====
// shared types, round constants, initial values and mixing functions for the sha-256 engine
package sha_pkg;

  localparam int WordW     = 32;
  localparam int CountW    = 3;
  localparam int IdxW      = 3;
  localparam int TdataW    = 40;
  localparam int FillW     = 6;
  localparam int RoundW    = 6;
  localparam int LenW      = 64;

  localparam logic [CountW-1:0] MaxBytes   = 3'd4;
  localparam logic [IdxW-1:0]   LastIdx256 = 3'd7;
  localparam logic [IdxW-1:0]   LastIdx224 = 3'd6;
  localparam logic [FillW-1:0]  LenFill    = 6'd56;
  localparam logic [RoundW-1:0] LastRound  = 6'd63;
  localparam logic [WordW-1:0]  PadWord    = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] Iv256 [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [WordW-1:0] Iv224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== rtl/core/sha256_hash_engine_top.sv =====
// sha-256 / sha-224 engine: byte packing, padding, iterative round unit and digest output
//
//  channel | ports               | payload, lowest bit first
//  --------+---------------------+-------------------------------------------------
//  in      | in_tvalid/in_tready | tdata: data_word[31:0], byte_count[34:32]; tlast: message_end
//  out     | out_tvalid/out_tready | tdata: digest_word[31:0], word_index[34:32]; tlast: last_word
//  cfg     | cfg_we              | cfg_wdata: digest_mode
//
// a transaction is taken in the idle state and the block is busy until done: an aligned full
// word is written whole, an unaligned or partial one a byte at a time.
// each 64-byte block runs through the shared round unit (64 rounds, then the add) before
// input resumes; the final transaction adds the 0x80 byte, the zero words, the length, each
// compression and the digest words out.
// synchronous active-low reset; no clearing pass. out_tready low holds the digest in place.
module sha256_hash_engine_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,     // digest_mode
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sha_pkg::TdataW-1:0]   in_tdata,      // data_word, byte_count, zero fill
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sha_pkg::TdataW-1:0]   out_tdata,     // digest_word, word_index, zero fill
  output logic                         out_tlast
);

  localparam int W = sha_pkg::WordW;

  sha_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic                          mode_r, mode_nxt;
  logic [W-1:0]                  hash_r [8];
  logic [W-1:0]                  hash_nxt [8];
  logic [W-1:0]                  wv_r [8];
  logic [W-1:0]                  wv_nxt [8];
  logic [W-1:0]                  buf_r [16];
  logic [sha_pkg::FillW-1:0]     fill_r, fill_nxt;
  logic [sha_pkg::LenW-1:0]      bitlen_r, bitlen_nxt;
  logic [sha_pkg::RoundW-1:0]    round_r, round_nxt;
  logic [W-1:0]                  data_r, data_nxt;
  logic [sha_pkg::CountW-1:0]    left_r, left_nxt;
  logic                          end_r, end_nxt;
  logic [sha_pkg::IdxW-1:0]      oidx_r, oidx_nxt;

  logic                          word_path;
  logic [1:0]                    lane_pos;
  logic [sha_pkg::FillW:0]       step_sum;
  logic                          step_wrap;
  logic                          wr_en, len_wr;
  logic [3:0]                    wr_mask;
  logic [W-1:0]                  wr_val;
  logic [sha_pkg::IdxW-1:0]      last_idx;
  logic                          out_last;
  logic [sha_pkg::CountW-1:0]    in_count;

  logic [W-1:0]                  t1, t2, w_new;

  assign lane_pos  = fill_r[1:0];
  assign word_path = (lane_pos == 2'd0) && (left_r == sha_pkg::MaxBytes);
  assign last_idx  = mode_r ? sha_pkg::LastIdx224 : sha_pkg::LastIdx256;
  assign out_last  = (oidx_r == last_idx);
  assign in_count  = (in_tdata[34:32] > sha_pkg::MaxBytes) ? sha_pkg::MaxBytes
                                                           : in_tdata[34:32];

  // fill position after this cycle's buffer write; carry out means the block is full
  always_comb begin
    unique case (state_r)
      sha_pkg::ST_DATA:  step_sum = {1'b0, fill_r} + (word_path ? 7'd4 : 7'd1);
      sha_pkg::ST_PAD80: step_sum = {({1'b0, fill_r[5:2]} + 5'd1), 2'b00};
      sha_pkg::ST_PADZ:  step_sum = {1'b0, fill_r} + 7'd4;
      default:           step_sum = {1'b0, fill_r};
    endcase
  end
  assign step_wrap = step_sum[sha_pkg::FillW];

  // round unit and message schedule window
  always_comb begin
    t1 = wv_r[7] + sha_pkg::big_sigma1(wv_r[4])
         + (wv_r[6] ^ (wv_r[4] & (wv_r[5] ^ wv_r[6])))
         + sha_pkg::RoundK[round_r] + buf_r[0];
    t2 = sha_pkg::big_sigma0(wv_r[0])
         + (((wv_r[0] | wv_r[1]) & wv_r[2]) | (wv_r[0] & wv_r[1]));
    w_new = sha_pkg::small_sigma1(buf_r[14]) + buf_r[9]
            + sha_pkg::small_sigma0(buf_r[1]) + buf_r[0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = sha_pkg::ST_DATA;
      end
      sha_pkg::ST_DATA: begin
        if (left_r == '0) state_nxt = end_r ? sha_pkg::ST_PAD80 : sha_pkg::ST_IDLE;
        else if (step_wrap) state_nxt = sha_pkg::ST_COMP;
      end
      sha_pkg::ST_PAD80: begin
        state_nxt = step_wrap ? sha_pkg::ST_COMP : sha_pkg::ST_PADZ;
      end
      sha_pkg::ST_PADZ: begin
        if (fill_r == sha_pkg::LenFill) state_nxt = sha_pkg::ST_LEN;
        else if (step_wrap) state_nxt = sha_pkg::ST_COMP;
      end
      sha_pkg::ST_LEN: begin
        state_nxt = sha_pkg::ST_COMP;
      end
      sha_pkg::ST_COMP: begin
        if (round_r == sha_pkg::LastRound) state_nxt = sha_pkg::ST_ADD;
      end
      sha_pkg::ST_ADD: begin
        state_nxt = ret_r;
      end
      sha_pkg::ST_OUT: begin
        if (out_tready && out_last) state_nxt = sha_pkg::ST_IDLE;
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mode_nxt   = mode_r;
    hash_nxt   = hash_r;
    wv_nxt     = wv_r;
    fill_nxt   = fill_r;
    bitlen_nxt = bitlen_r;
    round_nxt  = round_r;
    data_nxt   = data_r;
    left_nxt   = left_r;
    end_nxt    = end_r;
    oidx_nxt   = oidx_r;
    ret_nxt    = ret_r;
    wr_en      = 1'b0;
    len_wr     = 1'b0;
    wr_mask    = 4'b1111;
    wr_val     = '0;

    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          data_nxt = in_tdata[W-1:0];
          left_nxt = in_count;
          end_nxt  = in_tlast;
        end
      end
      sha_pkg::ST_DATA: begin
        if (left_r != '0) begin
          wr_en    = 1'b1;
          fill_nxt = step_sum[sha_pkg::FillW-1:0];
          ret_nxt  = sha_pkg::ST_DATA;
          if (word_path) begin
            wr_val     = data_r;
            bitlen_nxt = bitlen_r + 64'd32;
            left_nxt   = '0;
          end else begin
            // a byte starting a word clears the lanes below it
            wr_mask    = (lane_pos == 2'd0) ? 4'b1111 : (4'b0001 << lane_pos);
            wr_val     = {data_r[31:24], 24'h000000} >> {lane_pos, 3'b000};
            bitlen_nxt = bitlen_r + 64'd8;
            data_nxt   = {data_r[23:0], 8'h00};
            left_nxt   = left_r - 3'd1;
          end
        end
      end
      sha_pkg::ST_PAD80: begin
        wr_en    = 1'b1;
        wr_mask  = 4'b1111 << lane_pos;
        wr_val   = sha_pkg::PadWord >> {lane_pos, 3'b000};
        fill_nxt = step_sum[sha_pkg::FillW-1:0];
        ret_nxt  = sha_pkg::ST_PADZ;
      end
      sha_pkg::ST_PADZ: begin
        if (fill_r != sha_pkg::LenFill) begin
          wr_en    = 1'b1;
          fill_nxt = step_sum[sha_pkg::FillW-1:0];
          ret_nxt  = sha_pkg::ST_PADZ;
        end
      end
      sha_pkg::ST_LEN: begin
        len_wr   = 1'b1;
        fill_nxt = '0;
        ret_nxt  = sha_pkg::ST_OUT;
      end
      sha_pkg::ST_COMP: begin
        wv_nxt[7] = wv_r[6];
        wv_nxt[6] = wv_r[5];
        wv_nxt[5] = wv_r[4];
        wv_nxt[4] = wv_r[3] + t1;
        wv_nxt[3] = wv_r[2];
        wv_nxt[2] = wv_r[1];
        wv_nxt[1] = wv_r[0];
        wv_nxt[0] = t1 + t2;
        round_nxt = round_r + 6'd1;
      end
      sha_pkg::ST_ADD: begin
        for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + wv_r[i];
      end
      sha_pkg::ST_OUT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (out_last) begin
            oidx_nxt   = '0;
            fill_nxt   = '0;
            bitlen_nxt = '0;
            for (int i = 0; i < 8; i++) hash_nxt[i] = mode_r ? sha_pkg::Iv224[i]
                                                             : sha_pkg::Iv256[i];
          end
        end
      end
      default: ;
    endcase

    // entering the round loop loads the working variables from the chaining value
    if (state_nxt == sha_pkg::ST_COMP && state_r != sha_pkg::ST_COMP) begin
      wv_nxt    = hash_r;
      round_nxt = '0;
    end

    // a mode change reloads the initial values only while no bits are counted and the buffer is empty
    if (cfg_we) begin
      mode_nxt = cfg_wdata;
      if (bitlen_r == '0 && fill_r == '0) begin
        for (int i = 0; i < 8; i++) hash_nxt[i] = cfg_wdata ? sha_pkg::Iv224[i]
                                                            : sha_pkg::Iv256[i];
      end
    end
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == sha_pkg::ST_IDLE);
    out_tvalid = (state_r == sha_pkg::ST_OUT);
    out_tdata  = {5'b00000, oidx_r, hash_r[oidx_r]};
    out_tlast  = out_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha_pkg::ST_IDLE;
      ret_r    <= sha_pkg::ST_IDLE;
      mode_r   <= 1'b0;
      fill_r   <= '0;
      bitlen_r <= '0;
      round_r  <= '0;
      left_r   <= '0;
      end_r    <= 1'b0;
      oidx_r   <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= sha_pkg::Iv256[i];
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      mode_r   <= mode_nxt;
      fill_r   <= fill_nxt;
      bitlen_r <= bitlen_nxt;
      round_r  <= round_nxt;
      left_r   <= left_nxt;
      end_r    <= end_nxt;
      oidx_r   <= oidx_nxt;
      hash_r   <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    wv_r   <= wv_nxt;
  end

  // block buffer doubles as the schedule window while the rounds run
  always_ff @(posedge clk) begin
    if (state_r == sha_pkg::ST_COMP) begin
      for (int i = 0; i < 15; i++) buf_r[i] <= buf_r[i + 1];
      buf_r[15] <= w_new;
    end else begin
      if (wr_en) begin
        for (int l = 0; l < 4; l++) begin
          if (wr_mask[l]) buf_r[fill_r[5:2]][31 - 8*l -: 8] <= wr_val[31 - 8*l -: 8];
        end
      end
      if (len_wr) begin
        buf_r[14] <= bitlen_r[63:32];
        buf_r[15] <= bitlen_r[31:0];
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while digest pending");

  a_out_block_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fill_r == '0)
    else $error("digest shown with bytes still buffered");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::ST_COMP && round_r == sha_pkg::LastRound)
      |=> state_r == sha_pkg::ST_ADD)
    else $error("round loop did not finish after the last round");

  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && bitlen_r == '0))
    else $error("engine not re-initialised after the last digest word");

endmodule

// ===== tb/sha256_digest_checker.sv =====
// watches the sha-256 engine channels, predicts each digest and compares the output words
module sha256_digest_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [sha_pkg::TdataW-1:0] in_tdata,
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [sha_pkg::TdataW-1:0] out_tdata,
  input  logic                       out_tlast,
  output int                         mismatches,
  output int                         awaiting
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  localparam logic [31:0] RndK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] Start256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] Start224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  logic         sha_mode;
  logic [31:0]  chain [8];
  logic [31:0]  msg_block [16];
  int unsigned  byte_fill;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q [$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_chain();
    int i;
    for (i = 0; i < 8; i++) chain[i] = sha_mode ? Start224[i] : Start256[i];
    byte_fill = 0;
    msg_bits  = '0;
  endfunction

  function automatic void run_rounds();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, mj;
    int i;
    for (i = 0; i < 16; i++) w[i] = msg_block[i];
    for (i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (i = 0; i < 8; i++) v[i] = chain[i];
    for (i = 0; i < 64; i++) begin
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch + RndK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    int slot, lane;
    slot = byte_fill / 4;
    lane = byte_fill % 4;
    // first byte of a word clears the lower lanes
    if (lane == 0) msg_block[slot] = {b, 24'h0};
    else msg_block[slot][31-8*lane -: 8] = b;
    byte_fill++;
    if (byte_fill == 64) begin
      run_rounds();
      byte_fill = 0;
    end
  endfunction

  function automatic void absorb_item(input logic [31:0] data, input logic [2:0] cnt,
                                      input logic fin);
    int k, valid, words;
    digest_beat_t beat;
    valid = (cnt > 3'd4) ? 4 : int'(cnt);
    for (k = 0; k < valid; k++) begin
      absorb_byte(data[31-8*k -: 8]);
      msg_bits = msg_bits + 64'd8;
    end
    if (!fin) return;
    absorb_byte(8'h80);
    // no room left for the length: pad out this block and start another
    if (byte_fill > 56) while (byte_fill != 0) absorb_byte(8'h00);
    while (byte_fill < 56) absorb_byte(8'h00);
    msg_block[14] = msg_bits[63:32];
    msg_block[15] = msg_bits[31:0];
    run_rounds();
    byte_fill = 0;
    words = sha_mode ? 7 : 8;
    for (k = 0; k < words; k++) begin
      beat.word = chain[k];
      beat.idx  = 3'(k);
      beat.fin  = (k == words - 1);
      digest_q.push_back(beat);
    end
    restart_chain();
  endfunction

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst_n) begin
      sha_mode = 1'b0;
      restart_chain();
      digest_q.delete();
    end else begin
      if (cfg_we) begin
        sha_mode = cfg_wdata;
        // nothing held yet: new mode's start values take effect at once
        if (msg_bits == 0 && byte_fill == 0) restart_chain();
      end
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected digest transaction: word %h idx %0d last %b",
                   $time, out_tdata[31:0], out_tdata[34:32], out_tlast);
        end else begin
          want = digest_q.pop_front();
          if (out_tdata[31:0] !== want.word || out_tdata[34:32] !== want.idx ||
              out_tlast !== want.fin) begin
            mismatches++;
            $display("%0t: digest mismatch: expected word %h idx %0d last %b, got %h %0d %b",
                     $time, want.word, want.idx, want.fin,
                     out_tdata[31:0], out_tdata[34:32], out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) absorb_item(in_tdata[31:0], in_tdata[34:32], in_tlast);
    end
    awaiting = digest_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// stimulus, clocking and verdict for the sha-256 / sha-224 engine
module testbench;

  localparam int CycleLimit = 500000;
  localparam int SettleGap  = 200;
  localparam int SqueezeLen = 600;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic                       cfg_wdata;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [sha_pkg::TdataW-1:0] in_tdata;
  logic                       in_tlast;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [sha_pkg::TdataW-1:0] out_tdata;
  logic                       out_tlast;

  int   mismatches;
  int   awaiting;
  int   cycles = 0;
  int   items_sent = 0;
  logic steady = 1'b0;
  logic squeeze = 1'b0;

  always #1 clk = ~clk;

  sha256_hash_engine_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  sha256_digest_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off once squeeze is raised
  initial begin
    int  hold;
    logic held_once;
    hold = 0;
    held_once = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !held_once && out_tvalid) begin
        hold = SqueezeLen;
        held_once = 1'b1;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
    while (!steady && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(sha_pkg::TdataW-35){1'b0}}, cnt, data};
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle(input int extra);
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly full words; now and then a short or oversized count mid-message, and any count on the last one
  task automatic send_message(input int n_items);
    int k;
    logic [2:0] cnt;
    for (k = 0; k < n_items - 1; k++) begin
      cnt = ($urandom_range(99) < 10) ? 3'($urandom_range(7)) : 3'd4;
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    // lengths gathered around the one- and two-block padding boundaries
    if (r < 30) return $urandom_range(1, 4);
    if (r < 70) return $urandom_range(13, 18);
    if (r < 85) return $urandom_range(29, 34);
    return $urandom_range(1, 40);
  endfunction

  initial begin
    int phase;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty message, short word with junk below the valid bytes, data extremes
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'h6162_63ff, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    // oversized and partial counts on non-final transactions, empty one in the middle
    send_word(32'hdead_beef, 3'd7, 1'b0);
    send_word(32'h0123_4567, 3'd5, 1'b0);
    send_word(32'h89ab_cdef, 3'd6, 1'b0);
    send_word(32'hffff_ffff, 3'd1, 1'b0);
    send_word(32'h5a5a_5a5a, 3'd2, 1'b0);
    send_word(32'ha5a5_a5a5, 3'd3, 1'b0);
    send_word(32'hffff_ffff, 3'd0, 1'b0);
    send_word(32'h1234_5678, 3'd2, 1'b1);
    // sha-224 selected between messages
    settle(SettleGap);
    write_mode(1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    // mode change part way through a message: word count follows at once
    send_word(32'h0f0f_0f0f, 3'd4, 1'b0);
    send_word(32'hf0f0_f0f0, 3'd4, 1'b0);
    settle(SettleGap);
    write_mode(1'b0);
    send_word(32'h7777_7777, 3'd1, 1'b1);
    // mode change after an empty non-final transaction, nothing held yet
    settle(SettleGap);
    write_mode(1'b1);
    send_word(32'hcafe_f00d, 3'd0, 1'b0);
    settle(SettleGap);
    write_mode(1'b0);
    send_word(32'hcafe_f00d, 3'd4, 1'b1);

    items_sent = 0;
    for (phase = 0; phase < 6; phase++) begin
      settle(SettleGap);
      if (phase == 0) write_mode(1'b1);
      else if (phase == 1) write_mode(1'b0);
      else write_mode(1'($urandom_range(1)));
      steady  = (phase == 2);
      if (phase == 3) squeeze = 1'b1;
      while (items_sent < 50 * (phase + 1)) send_message(pick_length());
    end
    steady = 1'b0;

    settle(SettleGap);
    if (mismatches == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sha_pkg.sv
rtl/core/sha256_hash_engine_top.sv
tb/sha256_digest_checker.sv
tb/testbench.sv
